>>> design/assert_macros.svh
// Assertion macros shared by the row mirror sepia filter RTL.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property that is ignored while reset is asserted (active low).
`define AST_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define AST_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/rmsf_pkg.sv
// Types and constants of the row mirror sepia filter.
// Used by rmsf_cell, rmsf_sepia and row_mirror_sepia_filter; depends on nothing.
package rmsf_pkg;

    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned ROW_WIDTH_W = 7;
    localparam int unsigned CFG_IDX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_EN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPIA_EN   = 2'd2;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 7'd64;

    typedef logic [CHAN_W-1:0] t_chan;

    // Red in the lowest bits, blue in the highest
    typedef struct packed {
        t_chan blue;
        t_chan green;
        t_chan red;
    } t_pixel;

    localparam int unsigned PIX_W = $bits(t_pixel);

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

    // Sepia matrix in thousandths
    localparam int unsigned COEF_W = 10;
    localparam logic [COEF_W-1:0] C_RR = 10'd393;
    localparam logic [COEF_W-1:0] C_RG = 10'd769;
    localparam logic [COEF_W-1:0] C_RB = 10'd189;
    localparam logic [COEF_W-1:0] C_GR = 10'd349;
    localparam logic [COEF_W-1:0] C_GG = 10'd686;
    localparam logic [COEF_W-1:0] C_GB = 10'd168;
    localparam logic [COEF_W-1:0] C_BR = 10'd272;
    localparam logic [COEF_W-1:0] C_BG = 10'd534;
    localparam logic [COEF_W-1:0] C_BB = 10'd131;

    // Largest weighted sum is 1351 * 255, below 2^19
    localparam int unsigned SUM_W = 19;

    // Division by 1000 as multiplication by ceil(2^29 / 1000), exact for sums below 2^19
    localparam int unsigned RECIP_W     = 20;
    localparam int unsigned RECIP_SHIFT = 29;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 20'd536871;
    localparam int unsigned PROD_W      = SUM_W + RECIP_W;
    localparam int unsigned QUO_W       = 9;
    localparam logic [QUO_W-1:0] CHAN_MAX_Q = 9'd255;

    function automatic logic [SUM_W-1:0] dot3(t_pixel p, logic [COEF_W-1:0] cr,
                                              logic [COEF_W-1:0] cg,
                                              logic [COEF_W-1:0] cb);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p.red) * SUM_W'(cr) + SUM_W'(p.green) * SUM_W'(cg)
            + SUM_W'(p.blue) * SUM_W'(cb);
        return s;
    endfunction

endpackage

>>> design/row_mirror_sepia_filter.sv
// Row mirror and sepia filter for a row-major RGB pixel stream.
// Pixels enter on s_axis (tdata: red, green, blue from bit 0 up) and leave on
// m_axis with tlast marking the last pixel of each outgoing row.
// Registers are written over the cfg channel (index 0 row width, 1 mirror
// enable, 2 sepia enable); o_cfg_ready is always high. Write them only while
// no pixel is in flight.
// Every pixel is pushed into a chain of MAX_ROW_WIDTH cells acting as a stack.
// Mirror off: a pixel goes through the first stage and the output register to
// m_axis, one pixel per cycle while the receiver keeps up. Mirror on: the row's
// pixels are absorbed one per cycle; after the last one the chain pops the row
// back out, one pixel per cycle, with s_axis_tready low during the pop.
// Sepia uses the same stages: the weighted sums are registered in the first stage,
// then divided and clamped on their way into the output register.
// Reset (synchronous, active low) empties the pipeline, clears the column
// count and restores row width 64, mirror off, sepia off.
// A stalled receiver freezes the whole pipeline, the pop sequence included;
// the input side keeps taking pixels only while the output register is empty or drains.
`include "assert_macros.svh"
module row_mirror_sepia_filter
    import rmsf_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ROW_WIDTH_W-1:0] i_cfg_data,
    // pixel input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIX_W-1:0]       s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    // pixel output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [PIX_W-1:0]       m_axis_tdata,  // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic                   m_axis_tlast   // row_end
);

    localparam int COL_W = $clog2(MAX_ROW_WIDTH);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_BURST
    } t_state;

    t_state                 r_state;
    logic [ROW_WIDTH_W-1:0] r_row_width;
    logic                   r_mirror;
    logic                   r_sepia;
    logic [COL_W-1:0]       r_col;
    logic [COL_W-1:0]       r_idx;

    logic [ROW_WIDTH_W-1:0] w_eff_width;
    logic                   w_last;
    logic                   w_take;
    logic                   w_accept;
    t_cell_ctl              w_ctl;
    t_pixel                 w_in_pix;
    t_pixel                 w_cell_pix [MAX_ROW_WIDTH];
    logic                   w_emit_valid;
    t_pixel                 w_emit_pix;
    logic                   w_emit_last;
    t_pixel                 w_out_pix;

    assign o_cfg_ready = 1'b1;
    assign w_in_pix    = t_pixel'(s_axis_tdata);

    always_comb begin
        if (r_row_width == '0) begin
            w_eff_width = ROW_WIDTH_W'(1);
        end else if (r_row_width > ROW_WIDTH_W'(MAX_ROW_WIDTH)) begin
            w_eff_width = ROW_WIDTH_W'(MAX_ROW_WIDTH);
        end else begin
            w_eff_width = r_row_width;
        end
    end

    assign w_last = (ROW_WIDTH_W'(r_col) + ROW_WIDTH_W'(1)) >= w_eff_width;

    assign s_axis_tready = (r_state == ST_IDLE) && w_take;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_ctl.push = w_accept;
    assign w_ctl.pop  = (r_state == ST_BURST) && w_take;

    assign w_emit_valid = (w_accept && !r_mirror) || w_ctl.pop;
    assign w_emit_pix   = (r_state == ST_BURST) ? w_cell_pix[0] : w_in_pix;
    assign w_emit_last  = (r_state == ST_BURST) ? (r_idx == '0) : w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_width <= ROW_WIDTH_RST;
            r_mirror    <= 1'b0;
            r_sepia     <= 1'b0;
            r_col       <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ROW_WIDTH: r_row_width <= i_cfg_data;
                    CFG_MIRROR_EN: r_mirror    <= i_cfg_data[0];
                    CFG_SEPIA_EN:  r_sepia     <= i_cfg_data[0];
                    default:       ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_col <= w_last ? '0 : r_col + COL_W'(1);
                        if (w_last && r_mirror) begin
                            r_idx   <= r_col;
                            r_state <= ST_BURST;
                        end
                    end
                end
                ST_BURST: begin
                    if (w_take) begin
                        if (r_idx == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx - COL_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    for (genvar i = 0; i < MAX_ROW_WIDTH; i++) begin : g_chain
        t_pixel w_prev;
        t_pixel w_next;
        if (i == 0) begin : g_head
            assign w_prev = w_in_pix;
        end else begin : g_body
            assign w_prev = w_cell_pix[i-1];
        end
        if (i == MAX_ROW_WIDTH - 1) begin : g_tail
            assign w_next = t_pixel'('0);
        end else begin : g_inner
            assign w_next = w_cell_pix[i+1];
        end
        rmsf_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_from_prev (w_prev),
            .i_from_next (w_next),
            .o_pix       (w_cell_pix[i])
        );
    end

    rmsf_sepia u_sepia (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sepia_en (r_sepia),
        .i_valid    (w_emit_valid),
        .i_pix      (w_emit_pix),
        .i_last     (w_emit_last),
        .o_take     (w_take),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_pix      (w_out_pix),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = PIX_W'(w_out_pix);

    `AST_RST(a_no_input_in_burst, i_clk, i_rst_n, !((r_state == ST_BURST) && s_axis_tready), "input taken during burst")
    `AST_RST(a_burst_after_last, i_clk, i_rst_n, (w_accept && w_last && r_mirror) |=> (r_state == ST_BURST) && (r_col == '0), "mirrored row end did not start a burst")
    `AST_RST(a_burst_ends, i_clk, i_rst_n, ((r_state == ST_BURST) && w_take && (r_idx == '0)) |=> (r_state == ST_IDLE), "burst did not end after column zero")
    `AST_RST(a_col_wraps, i_clk, i_rst_n, (w_accept && w_last) |=> (r_col == '0), "column count not cleared at row end")

endmodule

>>> design/rmsf_cell.sv
// One cell of the line-store chain: holds one pixel, shifts with its neighbors.
// Depends on rmsf_pkg.
module rmsf_cell
    import rmsf_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_pixel    i_from_prev,
    input  t_pixel    i_from_next,
    output t_pixel    o_pix
);

    t_pixel r_pix;

    // Push moves data away from cell 0, pop moves it back toward cell 0
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.push) begin
            r_pix <= i_from_prev;
        end else if (i_ctl.pop) begin
            r_pix <= i_from_next;
        end
    end

    assign o_pix = r_pix;

endmodule

>>> design/rmsf_sepia.sv
// Two-stage sepia pipeline with the output register of the block.
// Depends on rmsf_pkg.
module rmsf_sepia
    import rmsf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_sepia_en,
    input  logic   i_valid,
    input  t_pixel i_pix,
    input  logic   i_last,
    output logic   o_take,
    output logic   o_valid,
    input  logic   i_ready,
    output t_pixel o_pix,
    output logic   o_last
);

    logic             r_s1_valid;
    t_pixel           r_s1_pix;
    logic             r_s1_last;
    logic [SUM_W-1:0] r_sum_r;
    logic [SUM_W-1:0] r_sum_g;
    logic [SUM_W-1:0] r_sum_b;

    logic   r_out_valid;
    t_pixel r_out_pix;
    logic   r_out_last;

    t_pixel n_sepia;

    // Whole pipeline moves when the output register is free or being drained
    assign o_take = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_s1_valid  <= i_valid;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_s1_pix   <= i_pix;
            r_s1_last  <= i_last;
            r_sum_r    <= dot3(i_pix, C_RR, C_RG, C_RB);
            r_sum_g    <= dot3(i_pix, C_GR, C_GG, C_GB);
            r_sum_b    <= dot3(i_pix, C_BR, C_BG, C_BB);
            r_out_pix  <= i_sepia_en ? n_sepia : r_s1_pix;
            r_out_last <= r_s1_last;
        end
    end

    function automatic t_chan div_clamp(logic [SUM_W-1:0] sum);
        logic [PROD_W-1:0] prod;
        logic [QUO_W-1:0]  q;
        prod = PROD_W'(sum) * PROD_W'(RECIP_1000);
        q    = prod[RECIP_SHIFT +: QUO_W];
        return (q > CHAN_MAX_Q) ? CHAN_MAX_Q[CHAN_W-1:0] : q[CHAN_W-1:0];
    endfunction

    always_comb begin
        n_sepia.red   = div_clamp(r_sum_r);
        n_sepia.green = div_clamp(r_sum_g);
        n_sepia.blue  = div_clamp(r_sum_b);
    end

    assign o_valid = r_out_valid;
    assign o_pix   = r_out_pix;
    assign o_last  = r_out_last;

endmodule

>>> verif/tb.sv
// Self-checking bench for row_mirror_sepia_filter: random pixel rows, mirror and sepia settings.
// Predicts each outgoing pixel in a small scoreboard class and checks the m_axis transfers.
// Depends on rmsf_pkg and the RTL under design/.
module tb
    import rmsf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROW_MAX       = 64;
    localparam int unsigned TARGET_PIXELS = 370;
    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned IDLE_LIMIT    = 20000;
    // index with no register behind it; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        t_pixel pix;
        logic   last;
    } row_beat_t;

    // Tracks row position and settings, and holds the pixels still owed by the block.
    class filter_tracker;
        t_pixel                 row_buf[ROW_MAX];
        int unsigned            col;
        logic [ROW_WIDTH_W-1:0] width_reg;
        bit                     mirror_on;
        bit                     sepia_on;
        row_beat_t              pending[$];
        int unsigned            errors;

        function new();
            col       = 0;
            width_reg = 7'd64;
            mirror_on = 1'b0;
            sepia_on  = 1'b0;
            errors    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [ROW_WIDTH_W-1:0] val);
            case (idx)
                CFG_ROW_WIDTH: width_reg = val;
                CFG_MIRROR_EN: mirror_on = val[0];
                CFG_SEPIA_EN:  sepia_on  = val[0];
                default: ;
            endcase
        endfunction

        // weighted sum in thousandths, truncated, saturated at 255
        function int unsigned weigh(t_pixel p, int unsigned kr, int unsigned kg,
                                    int unsigned kb);
            int unsigned q;
            q = (kr * p.red + kg * p.green + kb * p.blue) / 1000;
            return (q > 255) ? 255 : q;
        endfunction

        function t_pixel tone(t_pixel p);
            t_pixel r;
            if (!sepia_on) return p;
            r.red   = 8'(weigh(p, 393, 769, 189));
            r.green = 8'(weigh(p, 349, 686, 168));
            r.blue  = 8'(weigh(p, 272, 534, 131));
            return r;
        endfunction

        function void take_pixel(t_pixel p);
            int unsigned span;
            int unsigned c;
            bit          ends;
            row_beat_t   beat;
            span = (width_reg == 0) ? 1 : ((width_reg > ROW_MAX) ? ROW_MAX : width_reg);
            c    = (col > ROW_MAX - 1) ? ROW_MAX - 1 : col;
            row_buf[c] = p;
            ends = (c + 1 >= span);
            if (!mirror_on) begin
                beat.pix  = tone(p);
                beat.last = ends;
                pending.push_back(beat);
            end else if (ends) begin
                // burst covers every column of the row so far, newest first
                for (int i = c; i >= 0; i--) begin
                    beat.pix  = tone(row_buf[i]);
                    beat.last = (i == 0);
                    pending.push_back(beat);
                end
            end
            col = ends ? 0 : c + 1;
        endfunction

        function void compare_field(string label, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(t_pixel got, logic got_last);
            row_beat_t want;
            if (pending.size() == 0) begin
                $display("%0t: output pixel with none pending, expected nothing, got r %0d g %0d b %0d last %0b",
                         $time, got.red, got.green, got.blue, got_last);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("out_red", want.pix.red, got.red);
            compare_field("out_green", want.pix.green, got.green);
            compare_field("out_blue", want.pix.blue, got.blue);
            compare_field("row_end", want.last, got_last);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [ROW_WIDTH_W-1:0] i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [PIX_W-1:0]       s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [PIX_W-1:0]       m_axis_tdata;
    logic                   m_axis_tlast;

    filter_tracker tracker;
    int unsigned   pixels_sent = 0;
    bit            hold_request = 1'b0;
    bit            hold_active = 1'b0;

    row_mirror_sepia_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_pixel rgb(int unsigned r, int unsigned g, int unsigned b);
        t_pixel p;
        p.red   = 8'(r);
        p.green = 8'(g);
        p.blue  = 8'(b);
        return p;
    endfunction

    function automatic t_chan random_chan();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // Leaves i_cfg_valid high so writes can follow back to back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [ROW_WIDTH_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.set_register(idx, val);
        @(negedge i_clk);
    endtask

    task automatic configure(input int unsigned w, input bit m, input bit s);
        write_reg(CFG_ROW_WIDTH, ROW_WIDTH_W'(w));
        write_reg(CFG_MIRROR_EN, ROW_WIDTH_W'(m));
        write_reg(CFG_SEPIA_EN, ROW_WIDTH_W'(s));
        i_cfg_valid <= 1'b0;
    endtask

    // Returns at the falling edge after the transfer with tvalid still high.
    task automatic send_pixel(input t_pixel p);
        s_axis_tdata  <= p;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.take_pixel(p);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input bit steady);
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 9);
        if (steady || pick < 6) n = 0;
        else if (pick < 9) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 30);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic send_run(input int unsigned count, input bit steady);
        for (int unsigned i = 0; i < count; i++) begin
            send_pixel({random_chan(), random_chan(), random_chan()});
            idle_gap(steady);
        end
    endtask

    // Drop tvalid, wait for every owed pixel, then let absorbed pixels settle.
    task automatic wait_idle();
        int unsigned guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (tracker.pending.size() != 0 && guard < IDLE_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_pixel(t_pixel'(m_axis_tdata), m_axis_tlast);
        end
    end

    // Output side: random ready/stall pattern, plus one long hold-off on request.
    initial begin
        int unsigned pick;
        int unsigned run;
        int unsigned stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                hold_active = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
                hold_active  = 1'b0;
            end else begin
                pick = $urandom_range(0, 9);
                run = (pick < 2) ? $urandom_range(30, 100) : $urandom_range(1, 6);
                pick = $urandom_range(0, 9);
                if (pick < 4) stall = 0;
                else if (pick < 9) stall = $urandom_range(1, 3);
                else stall = $urandom_range(10, 40);
                m_axis_tready <= 1'b1;
                repeat (run) @(negedge i_clk);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("row_mirror_sepia_filter test failed");
        $finish;
    end

    initial begin
        int unsigned pick;
        int unsigned width_pick;
        int unsigned span;
        int unsigned count;
        bit          steady;

        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        tracker = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: pass-through, channel extremes
        send_pixel(rgb(0, 0, 0));
        send_pixel(rgb(255, 255, 255));
        send_pixel(rgb(255, 0, 0));
        send_pixel(rgb(0, 255, 0));
        send_pixel(rgb(0, 0, 255));
        wait_idle();

        // shrink the width mid-row: next pixel ends the row, sepia saturates
        write_reg(CFG_SPARE, 7'h7F);
        configure(3, 1'b0, 1'b1);
        send_pixel(rgb(255, 255, 255));
        send_pixel(rgb(1, 2, 3));
        idle_gap(1'b0);
        send_pixel(rgb(200, 100, 50));
        send_pixel(rgb(90, 180, 45));
        wait_idle();

        // zero width acts as one: each pixel is a one-pixel burst
        configure(0, 1'b1, 1'b0);
        send_pixel(rgb(17, 34, 51));
        send_pixel(rgb(250, 5, 128));
        wait_idle();

        // toggle mirroring mid-row; the burst includes passed-through pixels
        configure(4, 1'b1, 1'b1);
        send_pixel(rgb(10, 20, 30));
        send_pixel(rgb(40, 50, 60));
        wait_idle();
        configure(4, 1'b0, 1'b1);
        send_pixel(rgb(70, 80, 90));
        wait_idle();
        configure(4, 1'b1, 1'b0);
        send_pixel(rgb(100, 110, 120));
        wait_idle();

        // width above the maximum, then a mirrored row cut short mid-row
        configure(100, 1'b0, 1'b0);
        send_pixel(rgb(128, 64, 32));
        send_pixel(rgb(127, 63, 31));
        send_pixel(rgb(3, 6, 9));
        wait_idle();
        configure(2, 1'b1, 1'b1);
        send_pixel(rgb(255, 128, 0));
        wait_idle();

        // fill the block while the receiver holds off
        configure(16, 1'b0, 1'b1);
        hold_request = 1'b1;
        wait (hold_active);
        send_run(48, 1'b1);
        wait_idle();

        while (pixels_sent < TARGET_PIXELS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) width_pick = 0;
            else if (pick == 1) width_pick = ROW_MAX;
            else if (pick == 2) width_pick = $urandom_range(ROW_MAX + 1, 127);
            else if (pick < 6) width_pick = $urandom_range(9, ROW_MAX - 1);
            else width_pick = $urandom_range(1, 8);
            span = (width_pick == 0) ? 1 : ((width_pick > ROW_MAX) ? ROW_MAX : width_pick);
            count = span * ((span > 16) ? 1 : $urandom_range(1, 4));
            // now and then leave a row open for the next setting
            if ($urandom_range(0, 4) == 0) count += $urandom_range(1, span);
            if (count > TARGET_PIXELS - pixels_sent) count = TARGET_PIXELS - pixels_sent;
            steady = ($urandom_range(0, 3) == 0);
            configure(width_pick, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            send_run(count, steady);
            wait_idle();
        end

        if (tracker.pending.size() != 0) begin
            $display("%0t: %0d output pixels never arrived", $time, tracker.pending.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("row_mirror_sepia_filter test passed");
        end else begin
            $display("row_mirror_sepia_filter test failed");
        end
        $finish;
    end

endmodule
